// File: hw/rtl/rmr_pkg.sv
// Shared types and constants for the fraction add/multiply/reduce block
`timescale 1ns / 1ps
`default_nettype none

package rmr_pkg;

    localparam int OPD_W  = 16;
    localparam int FUNC_W = 2;
    localparam int IN_W   = 16;
    localparam int NUM_W  = 33;
    localparam int DEN_W  = 32;
    localparam int PROD_W = 2 * OPD_W;
    localparam int UW     = NUM_W;
    localparam int CNT_W  = $clog2(UW + 1);

    localparam logic [FUNC_W-1:0] FN_ADD  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_MUL  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_EQ   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_NONE = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IN_W-1:0]   a_num;
        logic [IN_W-1:0]   a_den;
        logic [IN_W-1:0]   b_num;
        logic [IN_W-1:0]   b_den;
    } t_in_req;

    typedef struct packed {
        logic [NUM_W-1:0] res_num;
        logic [DEN_W-1:0] res_den;
        logic             res_empty;
        logic             res_equal;
    } t_out_rsp;

    typedef enum logic {
        UOP_GCD,
        UOP_DIV
    } t_unit_op;

    typedef struct packed {
        logic          start;
        t_unit_op      op;
        logic [UW-1:0] x;
        logic [UW-1:0] y;
    } t_unit_req;

    typedef struct packed {
        logic          done;
        logic [UW-1:0] result;
    } t_unit_rsp;

endpackage

`default_nettype wire

// File: hw/rtl/rmr_unit.sv
// Shared subtract/shift unit: binary gcd and restoring division, one step per cycle
`timescale 1ns / 1ps
`default_nettype none

module rmr_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rmr_pkg::t_unit_req i_req,
    output rmr_pkg::t_unit_rsp      o_rsp
);

    typedef enum logic [1:0] {
        U_IDLE,
        U_GCD,
        U_DIV
    } t_ustate;

    t_ustate                     r_state;
    logic [rmr_pkg::UW-1:0]      r_x;
    logic [rmr_pkg::UW-1:0]      r_y;
    logic [rmr_pkg::UW:0]        r_rem;
    logic [rmr_pkg::CNT_W-1:0]   r_k;
    logic [rmr_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_done;
    logic [rmr_pkg::UW-1:0]      r_result;

    logic [rmr_pkg::UW:0]        rem_sh;
    logic [rmr_pkg::UW:0]        sub_a;
    logic [rmr_pkg::UW+1:0]      diff;
    logic                        ge;
    logic [rmr_pkg::UW-1:0]      gcd_out;
    logic                        done_now;

    assign rem_sh  = {r_rem[rmr_pkg::UW-1:0], r_x[rmr_pkg::UW-1]};
    assign sub_a   = (r_state == U_DIV) ? rem_sh : {1'b0, r_x};
    assign diff    = {1'b0, sub_a} - {2'b00, r_y};
    assign ge      = ~diff[rmr_pkg::UW+1];
    assign gcd_out = (r_x | r_y) << r_k;

    assign done_now = ((r_state == U_GCD) && (r_x == '0 || r_y == '0))
                   || ((r_state == U_DIV) && (r_cnt == rmr_pkg::CNT_W'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= done_now;
            unique case (r_state)
                U_IDLE: begin
                    if (i_req.start) begin
                        r_x   <= i_req.x;
                        r_y   <= i_req.y;
                        r_k   <= '0;
                        r_rem <= '0;
                        r_cnt <= rmr_pkg::CNT_W'(rmr_pkg::UW);
                        r_state <= (i_req.op == rmr_pkg::UOP_GCD) ? U_GCD : U_DIV;
                    end
                end
                U_GCD: begin
                    priority if (r_x == '0 || r_y == '0) begin
                        r_result <= gcd_out;
                        r_state  <= U_IDLE;
                    end else if (!r_x[0] && !r_y[0]) begin
                        r_x <= r_x >> 1;
                        r_y <= r_y >> 1;
                        r_k <= r_k + 1'b1;
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (ge) begin
                        r_x <= diff[rmr_pkg::UW-1:0];
                    end else begin
                        r_x <= r_y;
                        r_y <= r_x;
                    end
                end
                U_DIV: begin
                    r_rem <= ge ? diff[rmr_pkg::UW:0] : rem_sh;
                    r_x   <= {r_x[rmr_pkg::UW-2:0], ge};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == rmr_pkg::CNT_W'(1)) begin
                        r_result <= {r_x[rmr_pkg::UW-2:0], ge};
                        r_state  <= U_IDLE;
                    end
                end
                default: begin
                    r_state <= U_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_result;

endmodule

`default_nettype wire

// File: hw/rtl/rmr_mul.sv
// Multiplier with a registered product for the cross products
`timescale 1ns / 1ps
`default_nettype none

module rmr_mul (
    input  wire logic                        i_clk,
    input  wire logic [rmr_pkg::OPD_W-1:0]   i_x,
    input  wire logic [rmr_pkg::OPD_W-1:0]   i_y,
    output logic      [rmr_pkg::PROD_W-1:0]  o_p
);

    logic [rmr_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= rmr_pkg::PROD_W'(i_x) * rmr_pkg::PROD_W'(i_y);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// File: hw/rtl/rational_add_mul_reduce.sv
// Top level: sequencer, operand and result registers, output register
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries one request: an operation code
//   (add, multiply, equality compare) and two fractions of 16-bit fields. The
//   output channel o_out_valid / i_out_ready returns exactly one response per
//   request: reduced numerator and denominator, an empty flag and an equal flag.
//   One request is worked on at a time; o_in_ready is high only while idle.
//   The shared subtract/shift unit does one binary-gcd step or one quotient bit
//   per cycle; each operand and the result with a non-zero numerator and a
//   non-zero denominator need one gcd and two divisions.
//   A finished response waits in the output register while the receiver stalls,
//   and the next request is taken meanwhile; the sequencer holds its result
//   until the output register is free.
//   Reset is synchronous, active low, and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module rational_add_mul_reduce (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire rmr_pkg::t_in_req i_in_req,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output rmr_pkg::t_out_rsp     o_out_rsp
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_CHECK,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_STORE,
        S_BRANCH,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        SEL_A,
        SEL_B,
        SEL_RES
    } t_sel;

    t_state                          r_state;
    t_sel                            r_sel;
    logic [rmr_pkg::FUNC_W-1:0]      r_func;
    logic [rmr_pkg::OPD_W-1:0]       r_an;
    logic [rmr_pkg::OPD_W-1:0]       r_ad;
    logic [rmr_pkg::OPD_W-1:0]       r_bn;
    logic [rmr_pkg::OPD_W-1:0]       r_bd;
    logic [rmr_pkg::NUM_W-1:0]       r_rn;
    logic [rmr_pkg::DEN_W-1:0]       r_rd;
    logic                            r_rempty;
    logic [rmr_pkg::UW-1:0]          r_wn;
    logic [rmr_pkg::UW-1:0]          r_wd;
    logic [rmr_pkg::UW-1:0]          r_g;
    logic                            r_out_valid;
    rmr_pkg::t_out_rsp               r_out;

    rmr_pkg::t_unit_req              unit_req;
    rmr_pkg::t_unit_rsp              unit_rsp;
    logic [rmr_pkg::OPD_W-1:0]       mul_x;
    logic [rmr_pkg::OPD_W-1:0]       mul_y;
    logic [rmr_pkg::PROD_W-1:0]      mul_p;
    logic                            eq;
    logic                            arith;
    logic                            out_load;
    rmr_pkg::t_out_rsp               out_next;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    assign arith = (r_func == rmr_pkg::FN_ADD) || (r_func == rmr_pkg::FN_MUL);
    assign eq    = (r_ad != '0) && (r_an == r_bn) && (r_ad == r_bd);

    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        out_next = '0;
        if (arith) begin
            out_next.res_num   = r_rn;
            out_next.res_den   = r_rd;
            out_next.res_empty = r_rempty;
        end else if (r_func == rmr_pkg::FN_EQ) begin
            out_next.res_equal = eq;
        end
    end

    always_comb begin
        unit_req.start = ((r_state == S_CHECK) && (r_wd != '0) && (r_wn != '0))
                      || ((r_state == S_GCD) && unit_rsp.done)
                      || ((r_state == S_DIVN) && unit_rsp.done);
        unit_req.op    = (r_state == S_CHECK) ? rmr_pkg::UOP_GCD : rmr_pkg::UOP_DIV;
        unit_req.x     = (r_state == S_DIVN) ? r_wd : r_wn;
        unique case (r_state)
            S_CHECK: unit_req.y = r_wd;
            S_GCD:   unit_req.y = unit_rsp.result;
            default: unit_req.y = r_g;
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_MUL0: begin
                mul_x = r_an;
                mul_y = (r_func == rmr_pkg::FN_ADD) ? r_bd : r_bn;
            end
            S_MUL1: begin
                mul_x = r_ad;
                mul_y = r_bn;
            end
            default: begin
                mul_x = r_ad;
                mul_y = r_bd;
            end
        endcase
    end

    rmr_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (unit_req),
        .o_rsp   (unit_rsp)
    );

    rmr_mul u_mul (
        .i_clk (i_clk),
        .i_x   (mul_x),
        .i_y   (mul_y),
        .o_p   (mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= SEL_A;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_func  <= i_in_req.func;
                        r_an    <= i_in_req.a_num[rmr_pkg::OPD_W-1:0];
                        r_ad    <= i_in_req.a_den[rmr_pkg::OPD_W-1:0];
                        r_bn    <= i_in_req.b_num[rmr_pkg::OPD_W-1:0];
                        r_bd    <= i_in_req.b_den[rmr_pkg::OPD_W-1:0];
                        r_sel   <= SEL_A;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_wn    <= (r_sel == SEL_A) ? rmr_pkg::UW'(r_an) : rmr_pkg::UW'(r_bn);
                    r_wd    <= (r_sel == SEL_A) ? rmr_pkg::UW'(r_ad) : rmr_pkg::UW'(r_bd);
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    priority if (r_wd == '0) begin
                        r_wn    <= '0;
                        r_state <= S_STORE;
                    end else if (r_wn == '0) begin
                        r_state <= S_STORE;
                    end else begin
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (unit_rsp.done) begin
                        r_g     <= unit_rsp.result;
                        r_state <= S_DIVN;
                    end
                end
                S_DIVN: begin
                    if (unit_rsp.done) begin
                        r_wn    <= unit_rsp.result;
                        r_state <= S_DIVD;
                    end
                end
                S_DIVD: begin
                    if (unit_rsp.done) begin
                        r_wd    <= unit_rsp.result;
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    unique case (r_sel)
                        SEL_A: begin
                            r_an    <= r_wn[rmr_pkg::OPD_W-1:0];
                            r_ad    <= r_wd[rmr_pkg::OPD_W-1:0];
                            r_sel   <= SEL_B;
                            r_state <= S_LOAD;
                        end
                        SEL_B: begin
                            r_bn    <= r_wn[rmr_pkg::OPD_W-1:0];
                            r_bd    <= r_wd[rmr_pkg::OPD_W-1:0];
                            r_state <= S_BRANCH;
                        end
                        default: begin
                            r_rn    <= r_wn;
                            r_rd    <= r_wd[rmr_pkg::DEN_W-1:0];
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_BRANCH: begin
                    r_rn     <= '0;
                    r_rd     <= '0;
                    r_rempty <= arith && (r_ad == '0 || r_bd == '0);
                    if (!arith || r_ad == '0 || r_bd == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MUL0;
                    end
                end
                S_MUL0: begin
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_wn    <= rmr_pkg::UW'(mul_p);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    if (r_func == rmr_pkg::FN_ADD) begin
                        r_wn <= r_wn + rmr_pkg::UW'(mul_p);
                    end
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_wd    <= rmr_pkg::UW'(mul_p);
                    r_sel   <= SEL_RES;
                    r_state <= S_CHECK;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out   <= out_next;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rmr_checker.sv
// Port-level checker for the fraction add/multiply/reduce block, with bind
`timescale 1ns / 1ps
`default_nettype none

module rmr_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire rmr_pkg::t_out_rsp o_out_rsp
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_rsp))
        else $error("stalled response changed");

    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.res_empty |->
            o_out_rsp.res_num == '0 && o_out_rsp.res_den == '0 && !o_out_rsp.res_equal)
        else $error("empty result carries a value");

    a_equal_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.res_equal |->
            o_out_rsp.res_num == '0 && o_out_rsp.res_den == '0)
        else $error("compare response carries a fraction");

    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.res_num != '0 && o_out_rsp.res_den != '0 |->
            o_out_rsp.res_num[0] || o_out_rsp.res_den[0])
        else $error("result not reduced by common factor two");

endmodule

bind rational_add_mul_reduce rmr_checker u_rmr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_rsp   (o_out_rsp)
);

`default_nettype wire

// File: test/rmr_result_check.sv
// Response checker for the fraction add/multiply/reduce block: predicts and compares responses
`timescale 1ns / 1ps

module rmr_result_check (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  rmr_pkg::t_in_req  i_in_req,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  rmr_pkg::t_out_rsp i_out_rsp,
    output int                o_errors,
    output int                o_pending
);
    import rmr_pkg::*;

    typedef struct packed {
        logic [63:0] num;
        logic [63:0] den;
        logic        empty;
    } t_frac;

    t_out_rsp due_rsp[$];
    t_out_rsp want;
    int       fail_count;

    function automatic logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_frac reduced(logic [63:0] n, logic [63:0] d);
        t_frac       f;
        logic [63:0] g;
        f = '0;
        if (d == 0) begin
            f.empty = 1'b1;
        end else if (n == 0) begin
            f.den = d;
        end else begin
            g = gcd_of(n, d);
            f.num = n / g;
            f.den = d / g;
        end
        return f;
    endfunction

    function automatic t_out_rsp fraction_op(t_in_req r);
        t_frac    a;
        t_frac    b;
        t_frac    s;
        t_out_rsp o;
        a = reduced(64'(r.a_num[OPD_W-1:0]), 64'(r.a_den[OPD_W-1:0]));
        b = reduced(64'(r.b_num[OPD_W-1:0]), 64'(r.b_den[OPD_W-1:0]));
        o = '0;
        case (r.func)
            FN_ADD, FN_MUL: begin
                if (a.empty || b.empty) begin
                    o.res_empty = 1'b1;
                end else begin
                    if (r.func == FN_ADD) begin
                        s = reduced(a.num * b.den + a.den * b.num, a.den * b.den);
                    end else begin
                        s = reduced(a.num * b.num, a.den * b.den);
                    end
                    o.res_num   = s.num[NUM_W-1:0];
                    o.res_den   = s.den[DEN_W-1:0];
                    o.res_empty = s.empty;
                end
            end
            FN_EQ: begin
                o.res_equal = !a.empty && a.num == b.num && a.den == b.den;
            end
            default: begin
            end
        endcase
        return o;
    endfunction

    initial begin
        fail_count = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                due_rsp.push_back(fraction_op(i_in_req));
            end
            if (i_out_valid && i_out_ready) begin
                if (due_rsp.size() == 0) begin
                    $display("%0t: unexpected response num %0d den %0d empty %0b equal %0b",
                             $time, i_out_rsp.res_num, i_out_rsp.res_den,
                             i_out_rsp.res_empty, i_out_rsp.res_equal);
                    fail_count++;
                end else begin
                    want = due_rsp.pop_front();
                    if (i_out_rsp.res_num !== want.res_num
                            || i_out_rsp.res_den !== want.res_den
                            || i_out_rsp.res_empty !== want.res_empty
                            || i_out_rsp.res_equal !== want.res_equal) begin
                        $display("%0t: mismatch expected num %0d den %0d empty %0b equal %0b",
                                 $time, want.res_num, want.res_den,
                                 want.res_empty, want.res_equal);
                        $display("%0t:          actual num %0d den %0d empty %0b equal %0b",
                                 $time, i_out_rsp.res_num, i_out_rsp.res_den,
                                 i_out_rsp.res_empty, i_out_rsp.res_equal);
                        fail_count++;
                    end
                end
            end
            o_errors  <= fail_count;
            o_pending <= due_rsp.size();
        end
    end

endmodule

// File: test/rational_add_mul_reduce_tb.sv
// Testbench top for the fraction add/multiply/reduce block: stimulus, receiver stalls, verdict
`timescale 1ns / 1ps

module rational_add_mul_reduce_tb;
    import rmr_pkg::*;

    localparam int RANDOM_REQS = 1926;
    localparam int IDLE_LIMIT  = 10000;
    localparam int DRAIN_WAIT  = 600;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_req   i_in_req;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_rsp  o_out_rsp;
    int        errors;
    int        pending;
    int        idle_cycles;

    rational_add_mul_reduce DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    rmr_result_check u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_rsp   (o_out_rsp),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_in_req mk(logic [FUNC_W-1:0] f, logic [15:0] an, logic [15:0] ad,
                                   logic [15:0] bn, logic [15:0] bd);
        t_in_req r;
        r.func  = f;
        r.a_num = an;
        r.a_den = ad;
        r.b_num = bn;
        r.b_den = bd;
        return r;
    endfunction

    function automatic logic [15:0] pick_value();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'd0;
            1:       v = 16'hFFFF;
            2:       v = 16'($urandom_range(1, 15));
            3:       v = 16'd1 << $urandom_range(0, 15);
            7:       v = 16'($urandom_range(1, 255));
            default: v = 16'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    function automatic t_in_req random_request();
        t_in_req     r;
        logic [15:0] p;
        logic [15:0] q;
        int          sel;
        sel = $urandom_range(0, 15);
        if (sel <= 6) begin
            r.func = FN_ADD;
        end else if (sel <= 12) begin
            r.func = FN_MUL;
        end else if (sel <= 14) begin
            r.func = FN_EQ;
        end else begin
            r.func = FN_NONE;
        end
        r.a_num = pick_value();
        r.a_den = pick_value();
        r.b_num = pick_value();
        r.b_den = pick_value();
        if (r.func == FN_EQ && $urandom_range(0, 1) == 1) begin
            p = 16'($urandom_range(0, 255));
            q = 16'($urandom_range(1, 255));
            r.a_num = p * 16'($urandom_range(1, 255));
            r.a_den = q * (r.a_num == 0 ? 16'd1 : r.a_num / (p == 0 ? 16'd1 : p));
            r.b_num = p * 16'($urandom_range(1, 255));
            r.b_den = q * (r.b_num == 0 ? 16'd1 : r.b_num / (p == 0 ? 16'd1 : p));
        end else if ($urandom_range(0, 3) == 0) begin
            p = 16'($urandom_range(1, 255));
            r.a_num = p * 16'($urandom_range(0, 255));
            r.a_den = p * 16'($urandom_range(1, 255));
            q = 16'($urandom_range(1, 255));
            r.b_num = q * 16'($urandom_range(0, 255));
            r.b_den = q * 16'($urandom_range(1, 255));
        end
        if ($urandom_range(0, 11) == 0) begin
            r.a_den = 16'd0;
        end
        if ($urandom_range(0, 11) == 0) begin
            r.b_den = 16'd0;
        end
        return r;
    endfunction

    task automatic offer(input t_in_req r);
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    initial begin
        t_in_req directed[$];
        int      sent;
        int      burst;
        int      gap;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_req   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.push_back(mk(FN_ADD, 16'd1, 16'd2, 16'd1, 16'd3));
        directed.push_back(mk(FN_ADD, 16'd0, 16'd5, 16'd0, 16'd7));
        directed.push_back(mk(FN_ADD, 16'hFFFF, 16'hFFFE, 16'hFFFE, 16'hFFFD));
        directed.push_back(mk(FN_ADD, 16'd0, 16'd0, 16'd1, 16'd2));
        directed.push_back(mk(FN_ADD, 16'd3, 16'd4, 16'd5, 16'd0));
        directed.push_back(mk(FN_ADD, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0));
        directed.push_back(mk(FN_ADD, 16'd2, 16'd4, 16'd2, 16'd4));
        directed.push_back(mk(FN_ADD, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1));
        directed.push_back(mk(FN_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        directed.push_back(mk(FN_MUL, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1));
        directed.push_back(mk(FN_MUL, 16'd1, 16'hFFFF, 16'd1, 16'hFFFF));
        directed.push_back(mk(FN_MUL, 16'd0, 16'd3, 16'd4, 16'd6));
        directed.push_back(mk(FN_MUL, 16'd6, 16'd4, 16'd0, 16'd0));
        directed.push_back(mk(FN_MUL, 16'd12, 16'd8, 16'd2, 16'd3));
        directed.push_back(mk(FN_MUL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        directed.push_back(mk(FN_EQ, 16'd2, 16'd4, 16'd1, 16'd2));
        directed.push_back(mk(FN_EQ, 16'd0, 16'd0, 16'd0, 16'd0));
        directed.push_back(mk(FN_EQ, 16'd1, 16'd2, 16'd1, 16'd0));
        directed.push_back(mk(FN_EQ, 16'd0, 16'd4, 16'd0, 16'd2));
        directed.push_back(mk(FN_EQ, 16'd0, 16'd4, 16'd0, 16'd4));
        directed.push_back(mk(FN_EQ, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1));
        directed.push_back(mk(FN_EQ, 16'd3, 16'd5, 16'd5, 16'd3));
        directed.push_back(mk(FN_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        directed.push_back(mk(FN_NONE, 16'd0, 16'd0, 16'd0, 16'd0));
        foreach (directed[i]) begin
            offer(directed[i]);
        end
        i_in_valid <= 1'b0;
        repeat (3) @(posedge i_clk);

        sent = 0;
        while (sent < RANDOM_REQS) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < RANDOM_REQS; i++) begin
                offer(random_request());
                sent++;
            end
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 400) : $urandom_range(0, 4);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        int phase;
        int span;
        i_out_ready <= 1'b0;
        phase = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            phase++;
            if (phase == 40) begin
                i_out_ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
            end else begin
                case ($urandom_range(0, 2))
                    0: begin
                        span = $urandom_range(20, 400);
                        repeat (span) begin
                            i_out_ready <= 1'b1;
                            @(posedge i_clk);
                        end
                    end
                    1: begin
                        span = $urandom_range(10, 200);
                        repeat (span) begin
                            i_out_ready <= ($urandom_range(0, 3) != 0);
                            @(posedge i_clk);
                        end
                    end
                    default: begin
                        span = $urandom_range(1, 60);
                        repeat (span) begin
                            i_out_ready <= 1'b0;
                            @(posedge i_clk);
                        end
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule

// File: sim.f
hw/rtl/rmr_pkg.sv
hw/rtl/rmr_unit.sv
hw/rtl/rmr_mul.sv
hw/rtl/rational_add_mul_reduce.sv
hw/rtl/rmr_checker.sv
test/rmr_result_check.sv
test/rational_add_mul_reduce_tb.sv
